// ===== rtl/core/orf_pkg.sv =====
// ----------------------------------------------------------------------------
// orf_pkg: shared types and constants of the overwrite ring FIFO
// Field widths, action codes, controller states and the result word layout.
// ----------------------------------------------------------------------------
package orf_pkg;

  localparam int ACT_W      = 2;
  localparam int IN_WORD_W  = 32;
  localparam int OUT_WORD_W = 32;
  localparam int FILL_W     = 7;
  localparam int MAX_WORD_W = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_DUMP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic [OUT_WORD_W-1:0] out_word;
    logic                  word_valid;
    logic                  overwrote;
    logic                  is_empty;
    logic                  is_full;
    logic [FILL_W-1:0]     fill_count;
    logic                  last_of_run;
  } result_t;

endpackage

// ===== rtl/core/orf_in_if.sv =====
// ----------------------------------------------------------------------------
// orf_in_if: command channel of the overwrite ring FIFO
// Valid/ready channel that carries one action and one word to push.
// ----------------------------------------------------------------------------
interface orf_in_if;
  logic                           valid;
  logic                           ready;
  logic [orf_pkg::ACT_W-1:0]      action;
  logic [orf_pkg::IN_WORD_W-1:0]  push_word;

  modport source (output valid, output action, output push_word, input ready);
  modport sink   (input valid, input action, input push_word, output ready);
endinterface

// ===== rtl/core/orf_out_if.sv =====
// ----------------------------------------------------------------------------
// orf_out_if: result channel of the overwrite ring FIFO
// Valid/ready channel that carries one result word with queue status.
// ----------------------------------------------------------------------------
interface orf_out_if;
  logic                           valid;
  logic                           ready;
  logic [orf_pkg::OUT_WORD_W-1:0] out_word;
  logic                           word_valid;
  logic                           overwrote;
  logic                           is_empty;
  logic                           is_full;
  logic [orf_pkg::FILL_W-1:0]     fill_count;
  logic                           last_of_run;

  modport source (output valid, output out_word, output word_valid, output overwrote,
                  output is_empty, output is_full, output fill_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_word, input word_valid, input overwrote,
                  input is_empty, input is_full, input fill_count,
                  input last_of_run, output ready);
endinterface

// ===== rtl/core/orf_ram.sv =====
// ----------------------------------------------------------------------------
// orf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module orf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/orf_ctrl.sv =====
// ----------------------------------------------------------------------------
// orf_ctrl: queue controller of the overwrite ring FIFO
// Keeps head, tail and fill count, drives the slot RAM, sequences pops and
// dumps through the RAM read port and holds the result output register.
// ----------------------------------------------------------------------------
module orf_ctrl #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  orf_in_if.sink                   in_ch,
  orf_out_if.source                out_ch,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [WORD_BITS-1:0]     ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [WORD_BITS-1:0]     ram_rdata
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  orf_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  orf_pkg::result_t out_res_r, out_res_nxt;

  logic                         out_free;
  logic                         in_fire;
  logic                         is_full_now;
  logic [orf_pkg::MAX_WORD_W-1:0] push_ext;
  logic [orf_pkg::MAX_WORD_W-1:0] rd_ext;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic orf_pkg::result_t build_res(
    input logic [orf_pkg::OUT_WORD_W-1:0] word,
    input logic                           valid,
    input logic                           ovw,
    input logic [CNT_W-1:0]               cnt,
    input logic                           last
  );
    orf_pkg::result_t r;
    r.out_word    = word;
    r.word_valid  = valid;
    r.overwrote   = ovw;
    r.is_empty    = (cnt == '0);
    r.is_full     = (cnt == FULL_CNT);
    r.fill_count  = orf_pkg::FILL_W'(cnt);
    r.last_of_run = last;
    return r;
  endfunction

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == orf_pkg::ST_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_full_now = (count_r == FULL_CNT);
  assign push_ext    = orf_pkg::MAX_WORD_W'(in_ch.push_word);
  assign rd_ext      = orf_pkg::MAX_WORD_W'(ram_rdata);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    rd_ptr_nxt    = rd_ptr_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_wdata     = push_ext[WORD_BITS-1:0];
    ram_re        = 1'b0;
    ram_raddr     = head_r;

    unique case (state_r)
      orf_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (orf_pkg::action_t'(in_ch.action))
            orf_pkg::ACT_PUSH: begin
              // A push on a full queue drops the oldest word by moving head.
              ram_we    = 1'b1;
              tail_nxt  = wrap_next(tail_r);
              head_nxt  = is_full_now ? wrap_next(head_r) : head_r;
              count_nxt = is_full_now ? count_r : count_r + 1'b1;
              out_valid_nxt = 1'b1;
              out_res_nxt   = build_res('0, 1'b0, is_full_now, count_nxt, 1'b1);
            end
            orf_pkg::ACT_POP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = build_res('0, 1'b0, 1'b0, count_r, 1'b1);
              end else begin
                // The word comes back from the RAM in the next cycle.
                ram_re    = 1'b1;
                head_nxt  = wrap_next(head_r);
                count_nxt = count_r - 1'b1;
                rem_nxt   = '0;
                state_nxt = orf_pkg::ST_RUN;
              end
            end
            orf_pkg::ACT_CLEAR: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_res_nxt   = build_res('0, 1'b0, 1'b0, '0, 1'b1);
            end
            orf_pkg::ACT_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = build_res('0, 1'b0, 1'b0, count_r, 1'b1);
              end else begin
                ram_re     = 1'b1;
                rd_ptr_nxt = wrap_next(head_r);
                rem_nxt    = count_r - 1'b1;
                state_nxt  = orf_pkg::ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      orf_pkg::ST_RUN: begin
        // One read is always outstanding here; the next read is issued only
        // when the current word moves into the output register.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = build_res(rd_ext[orf_pkg::OUT_WORD_W-1:0], 1'b1, 1'b0,
                                    count_r, rem_r == '0);
          if (rem_r == '0) begin
            state_nxt = orf_pkg::ST_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = rd_ptr_r;
            rd_ptr_nxt = wrap_next(rd_ptr_r);
            rem_nxt    = rem_r - 1'b1;
          end
        end
      end
      default: state_nxt = orf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= orf_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_word    = out_res_r.out_word;
  assign out_ch.word_valid  = out_res_r.word_valid;
  assign out_ch.overwrote   = out_res_r.overwrote;
  assign out_ch.is_empty    = out_res_r.is_empty;
  assign out_ch.is_full     = out_res_r.is_full;
  assign out_ch.fill_count  = out_res_r.fill_count;
  assign out_ch.last_of_run = out_res_r.last_of_run;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above queue depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> (head_r == tail_r))
    else $error("head and tail disagree with an empty or full queue");

  a_run_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == orf_pkg::ST_RUN) |-> (rem_r < FULL_CNT && !ram_we))
    else $error("run sequencer out of range or writing the RAM");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == orf_pkg::ST_RUN && state_r == orf_pkg::ST_IDLE)
      |-> (out_valid_r && out_res_r.last_of_run && out_res_r.word_valid))
    else $error("run ended without a final marked word");

endmodule

// ===== rtl/core/overwrite_ring_fifo_top.sv =====
// Push and clear results, and results of pop or dump on an empty queue, appear
// in the result register in the cycle after the command word is accepted.
// Pop and dump words pass through the registered read port of the slot RAM
// and then the result register, one word per cycle while out_ch is not stalled.
// Throughput: one push or clear per cycle while out_ch takes each result; the next command waits for a run.
// Reset (rst_n low, synchronous) empties the queue; the RAM is not cleared.
// ----------------------------------------------------------------------------
// overwrite_ring_fifo_top: ring FIFO that overwrites its oldest word
// Slot RAM plus queue controller with a registered result output.
// ----------------------------------------------------------------------------
module overwrite_ring_fifo_top #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  orf_in_if.sink     in_ch,
  orf_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  orf_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  orf_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
